// File: hw/rtl/pida_pkg.sv
// Shared constants, request and status codes, and the check result type.
package pida_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [1:0] status;
  } chk_t;

endpackage

// File: hw/rtl/pida_check.sv
// Request validation: capacity, emptiness and position checks, and unknown codes.
module pida_check (
  input  logic [1:0]                  req_type,
  input  logic [pida_pkg::POS_W-1:0]  position,
  input  logic [pida_pkg::CNT_W-1:0]  count,
  output pida_pkg::chk_t              chk
);

  logic [pida_pkg::CMP_W-1:0] pos_x;
  logic [pida_pkg::CMP_W-1:0] cnt_x;
  logic                       full;
  logic                       empty;

  assign pos_x = pida_pkg::CMP_W'(position);
  assign cnt_x = pida_pkg::CMP_W'(count);
  assign full  = (count >= pida_pkg::CNT_W'(pida_pkg::DEPTH));
  assign empty = (count == '0);

  always_comb begin
    chk.status = pida_pkg::ST_OK;
    case (req_type)
      pida_pkg::REQ_INSERT: begin
        if (full) begin
          chk.status = pida_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          chk.status = pida_pkg::ST_RANGE;
        end
      end
      pida_pkg::REQ_DELETE, pida_pkg::REQ_READ: begin
        if (empty) begin
          chk.status = pida_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          chk.status = pida_pkg::ST_RANGE;
        end
      end
      default: chk.status = pida_pkg::ST_RANGE;
    endcase
    chk.ok = (chk.status == pida_pkg::ST_OK);
  end

endmodule

// File: hw/rtl/positional_insert_delete_array.sv
// Top level: packed word array with positional insert, delete and read.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+------------------------------------
//  request  | in        | start, accepted when !busy   | req_type, position, value
//  result   | out       | done, one cycle, no backpres. | read_data, element_count, status
//
// Elements move one place per S_STEP and S_MOVE pair through an array with one
// write port, a registered read and one shared index step unit. Busy after
// acceptance: an insert at p shifts the words from p up, a delete shifts those
// above p down and a read only fetches; done is high in the cycle busy falls. A
// rejected request keeps busy low and gives done on the next cycle. Reset clears
// the count; array words are not cleared. The result cannot be stalled.
module positional_insert_delete_array (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          req_type,
  input  logic [pida_pkg::POS_W-1:0]          position,
  input  logic signed [pida_pkg::DATA_W-1:0]  value,
  output logic                                done,
  output logic signed [pida_pkg::DATA_W-1:0]  read_data,
  output logic [pida_pkg::POS_W-1:0]          element_count,
  output logic [1:0]                          status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CAPT,
    S_STEP,
    S_MOVE
  } state_t;

  state_t                         state;
  logic [1:0]                     op;
  logic [pida_pkg::ADDR_W-1:0]    idx;
  logic [pida_pkg::ADDR_W-1:0]    pos_r;
  logic [pida_pkg::DATA_W-1:0]    val_r;
  logic [pida_pkg::DATA_W-1:0]    data_r;
  logic [pida_pkg::CNT_W-1:0]     count;

  logic [pida_pkg::DATA_W-1:0]    mem [pida_pkg::DEPTH];
  logic [pida_pkg::DATA_W-1:0]    rd_q;
  logic [pida_pkg::ADDR_W-1:0]    rd_addr;
  logic                           wr_en;
  logic [pida_pkg::ADDR_W-1:0]    wr_addr;
  logic [pida_pkg::DATA_W-1:0]    wr_data;

  logic [pida_pkg::ADDR_W-1:0]    idx_step;
  logic                           ins_more;
  logic                           del_more;
  pida_pkg::chk_t                 chk;

  pida_check u_check (
    .req_type (req_type),
    .position (position),
    .count    (count),
    .chk      (chk)
  );

  // shared index step: down for insert, up for delete
  assign idx_step = (op == pida_pkg::REQ_INSERT) ? (idx - 1'b1) : (idx + 1'b1);
  assign ins_more = (idx > pos_r);
  assign del_more = ((pida_pkg::CNT_W'(idx) + pida_pkg::CNT_W'(1)) < count);

  assign busy = (state != S_IDLE);

  always_comb begin
    rd_addr = idx_step;
    if (state == S_IDLE) begin
      rd_addr = position[pida_pkg::ADDR_W-1:0];
    end
    wr_en   = (state == S_MOVE) ||
              ((state == S_STEP) && (op == pida_pkg::REQ_INSERT) && !ins_more);
    wr_addr = (state == S_MOVE) ? idx : pos_r;
    wr_data = (state == S_MOVE) ? rd_q : val_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op    <= req_type;
            pos_r <= position[pida_pkg::ADDR_W-1:0];
            val_r <= value;
            idx   <= position[pida_pkg::ADDR_W-1:0];
            if (!chk.ok) begin
              done          <= 1'b1;
              read_data     <= '0;
              status        <= chk.status;
              element_count <= pida_pkg::POS_W'(count);
            end else if (req_type == pida_pkg::REQ_INSERT) begin
              idx   <= count[pida_pkg::ADDR_W-1:0];
              state <= S_STEP;
            end else begin
              state <= S_CAPT;
            end
          end
        end
        S_CAPT: begin
          if (op == pida_pkg::REQ_READ) begin
            done          <= 1'b1;
            read_data     <= rd_q;
            status        <= pida_pkg::ST_OK;
            element_count <= pida_pkg::POS_W'(count);
            state         <= S_IDLE;
          end else begin
            data_r <= rd_q;
            state  <= S_STEP;
          end
        end
        S_STEP: begin
          if (op == pida_pkg::REQ_INSERT) begin
            if (ins_more) begin
              state <= S_MOVE;
            end else begin
              count         <= count + 1'b1;
              done          <= 1'b1;
              read_data     <= '0;
              status        <= pida_pkg::ST_OK;
              element_count <= pida_pkg::POS_W'(count + 1'b1);
              state         <= S_IDLE;
            end
          end else begin
            if (del_more) begin
              state <= S_MOVE;
            end else begin
              count         <= count - 1'b1;
              done          <= 1'b1;
              read_data     <= data_r;
              status        <= pida_pkg::ST_OK;
              element_count <= pida_pkg::POS_W'(count - 1'b1);
              state         <= S_IDLE;
            end
          end
        end
        S_MOVE: begin
          idx   <= idx_step;
          state <= S_STEP;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pida_pkg::CNT_W'(pida_pkg::DEPTH))
    else $error("element count above capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result given while a request is still in progress");

  a_done_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (element_count == pida_pkg::POS_W'(count)))
    else $error("reported count differs from held count");

  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !chk.ok) |=> (count == $past(count)) && !busy)
    else $error("rejected transaction changed the array");

  a_work_legal: assert property (@(posedge clk) disable iff (rst)
    (busy && (op == pida_pkg::REQ_INSERT)) |->
      (count < pida_pkg::CNT_W'(pida_pkg::DEPTH)))
    else $error("insert in progress on a full array");

endmodule

// File: test/tb.sv
// Self-checking testbench for the positional insert/delete word array.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code with no meaning; the block must reject it.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * pida_pkg::DEPTH + 4;

  typedef struct packed {
    logic signed [pida_pkg::DATA_W-1:0] data;
    logic [pida_pkg::POS_W-1:0]         count;
    logic [1:0]                         status;
  } outcome_t;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               start;
  logic                               busy;
  logic [1:0]                         req_type;
  logic [pida_pkg::POS_W-1:0]         position;
  logic signed [pida_pkg::DATA_W-1:0] value;
  logic                               done;
  logic signed [pida_pkg::DATA_W-1:0] read_data;
  logic [pida_pkg::POS_W-1:0]         element_count;
  logic [1:0]                         status;

  logic signed [pida_pkg::DATA_W-1:0] shadow_words [pida_pkg::DEPTH];
  int                                 shadow_count;
  outcome_t                           pending_outcomes [$];
  int                                 mismatch_count;
  int                                 gap_pct;
  int                                 idle_cycles;

  positional_insert_delete_array DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .position      (position),
    .value         (value),
    .done          (done),
    .read_data     (read_data),
    .element_count (element_count),
    .status        (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the shadow array and return the result it should give.
  function automatic outcome_t apply_request(input logic [1:0] kind,
                                             input logic [pida_pkg::POS_W-1:0] pos,
                                             input logic signed [pida_pkg::DATA_W-1:0] val);
    outcome_t o;
    int       i;
    int       p;
    p        = int'(pos);
    o.data   = '0;
    o.status = pida_pkg::ST_OK;
    case (kind)
      pida_pkg::REQ_INSERT: begin
        if (shadow_count >= pida_pkg::DEPTH) begin
          o.status = pida_pkg::ST_FULL;
        end else if (p > shadow_count) begin
          o.status = pida_pkg::ST_RANGE;
        end else begin
          for (i = shadow_count; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = val;
          shadow_count++;
        end
      end
      pida_pkg::REQ_DELETE: begin
        if (shadow_count == 0) begin
          o.status = pida_pkg::ST_EMPTY;
        end else if (p >= shadow_count) begin
          o.status = pida_pkg::ST_RANGE;
        end else begin
          o.data = shadow_words[p];
          for (i = p; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      pida_pkg::REQ_READ: begin
        if (shadow_count == 0) begin
          o.status = pida_pkg::ST_EMPTY;
        end else if (p >= shadow_count) begin
          o.status = pida_pkg::ST_RANGE;
        end else begin
          o.data = shadow_words[p];
        end
      end
      default: begin
        o.status = pida_pkg::ST_RANGE;
      end
    endcase
    o.count = shadow_count[pida_pkg::POS_W-1:0];
    return o;
  endfunction

  // Offer one transaction, idling first at the current rate; keep start high afterwards.
  task automatic send_request(input logic [1:0] kind, input logic [pida_pkg::POS_W-1:0] pos,
                              input logic signed [pida_pkg::DATA_W-1:0] val);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    start    <= 1'b1;
    req_type <= kind;
    position <= pos;
    value    <= val;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(apply_request(kind, pos, val));
  endtask

  task automatic test_empty_requests();
    send_request(pida_pkg::REQ_READ, 5'd0, 32'sd7);
    send_request(pida_pkg::REQ_DELETE, 5'd0, -32'sd1);
    send_request(pida_pkg::REQ_INSERT, 5'd1, 32'sd5);
    send_request(REQ_UNUSED, 5'd0, 32'sd9);
  endtask

  task automatic test_fill_to_full();
    int                                 i;
    logic [pida_pkg::POS_W-1:0]         pos;
    logic signed [pida_pkg::DATA_W-1:0] val;
    for (i = 0; i < pida_pkg::DEPTH; i++) begin
      case (i % 3)
        0:       pos = '0;
        1:       pos = shadow_count[pida_pkg::POS_W-1:0];
        default: pos = pida_pkg::POS_W'(shadow_count / 2);
      endcase
      case (i)
        0:       val = 32'sh8000_0000;
        1:       val = 32'sh7FFF_FFFF;
        2:       val = '0;
        3:       val = -32'sd1;
        default: val = $urandom;
      endcase
      send_request(pida_pkg::REQ_INSERT, pos, val);
    end
    send_request(pida_pkg::REQ_INSERT, 5'd16, 32'sh5A5A_A5A5);
  endtask

  task automatic test_bounds_when_full();
    send_request(pida_pkg::REQ_READ, 5'd16, '0);
    send_request(pida_pkg::REQ_DELETE, 5'd31, '0);
    send_request(pida_pkg::REQ_DELETE, 5'd15, '0);
    send_request(pida_pkg::REQ_DELETE, 5'd0, '0);
  endtask

  // Mostly well-formed requests, with fill and drain spells to sweep the count.
  task automatic test_random_traffic(input int n_items, input int idle_pct);
    int                         k;
    int                         roll;
    bit                         filling;
    logic [1:0]                 kind;
    logic [pida_pkg::POS_W-1:0] pos;
    gap_pct = idle_pct;
    filling = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (shadow_count == 0) filling = 1'b1;
      else if (shadow_count == pida_pkg::DEPTH && $urandom_range(3) == 0) filling = 1'b0;
      else if ($urandom_range(39) == 0) filling = !filling;
      roll = $urandom_range(99);
      if (roll < 12) begin
        kind = 2'($urandom_range(3));
        pos  = pida_pkg::POS_W'($urandom_range(31));
      end else begin
        roll = $urandom_range(99);
        if (roll < (filling ? 60 : 25)) kind = pida_pkg::REQ_INSERT;
        else if (roll < (filling ? 85 : 70)) kind = pida_pkg::REQ_DELETE;
        else kind = pida_pkg::REQ_READ;
        if (kind == pida_pkg::REQ_INSERT) pos = pida_pkg::POS_W'($urandom_range(shadow_count));
        else if (shadow_count == 0) pos = '0;
        else pos = pida_pkg::POS_W'($urandom_range(shadow_count - 1));
      end
      send_request(kind, pos, $urandom);
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result data=%0d count=%0d status=%0d",
                 $time, read_data, element_count, status);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (read_data !== want.data) begin
          $display("%0t: read_data expected %0d actual %0d", $time, want.data, read_data);
          mismatch_count++;
        end
        if (element_count !== want.count) begin
          $display("%0t: element_count expected %0d actual %0d",
                   $time, want.count, element_count);
          mismatch_count++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when neither side moves a transaction for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst            <= 1'b1;
    start          <= 1'b0;
    req_type       <= pida_pkg::REQ_READ;
    position       <= '0;
    value          <= '0;
    shadow_count   = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    gap_pct        = 19;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_empty_requests();
    test_fill_to_full();
    test_bounds_when_full();
    test_random_traffic(200, 19);
    test_random_traffic(200, 82);
    test_random_traffic(200, 0);

    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
